/* hdl/sensor_payload_framer_core_assert.svh */
// Assertion macros shared by the sensor payload framer RTL.
`ifndef SENSOR_PAYLOAD_FRAMER_CORE_ASSERT_SVH
`define SENSOR_PAYLOAD_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sensor_payload_framer_core: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sensor_payload_framer_core: next-cycle check failed");

`endif

/* hdl/spf_pkg.sv */
// Shared types, codes, constants and character tables of the payload framer.
package spf_pkg;

  localparam int PAYLOAD_BYTES_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;

  // Input command codes.
  localparam logic [2:0] CMD_CLEAR      = 3'd0;
  localparam logic [2:0] CMD_ADD_TEMP   = 3'd1;
  localparam logic [2:0] CMD_ADD_ANALOG = 3'd2;
  localparam logic [2:0] CMD_ADD_HUMID  = 3'd3;
  localparam logic [2:0] CMD_EMIT_AT    = 3'd4;
  localparam logic [2:0] CMD_EMIT_HEX   = 3'd5;

  // Classified operations handed from the front to the back.
  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_ADD      = 3'd2;
  localparam logic [2:0] OP_EMIT_AT  = 3'd3;
  localparam logic [2:0] OP_EMIT_HEX = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_SMALL = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_TEMP_TYPE   = 2'd0;
  localparam logic [1:0] CFG_ANALOG_TYPE = 2'd1;
  localparam logic [1:0] CFG_HUMID_TYPE  = 2'd2;
  localparam logic [7:0] TEMP_TYPE_RESET   = 8'd103;
  localparam logic [7:0] ANALOG_TYPE_RESET = 8'd2;
  localparam logic [7:0] HUMID_TYPE_RESET  = 8'd104;

  // Clamp limits in hundredths.
  localparam logic signed [23:0] TEMP_MIN   = -24'sd327680;
  localparam logic signed [23:0] TEMP_MAX   = 24'sd327670;
  localparam logic signed [23:0] ANALOG_MIN = -24'sd32768;
  localparam logic signed [23:0] ANALOG_MAX = 24'sd32767;
  localparam logic signed [23:0] HUMID_MIN  = 24'sd0;
  localparam logic signed [23:0] HUMID_MAX  = 24'sd10000;

  // Reciprocals for the constant divisions: ceil(2^shift / divisor), exact over the
  // clamped magnitudes (up to 327680 for tenths, up to 10000 for half percent).
  localparam logic [19:0] TENTH_RECIP   = 20'd838861;
  localparam int          TENTH_SHIFT   = 23;
  localparam logic [19:0] HALFPCT_RECIP = 20'd20972;
  localparam int          HALFPCT_SHIFT = 20;

  // AT line framing: head characters, tail characters, and the room the line
  // needs beyond the hex digits, counting one terminator position.
  localparam int AT_HEAD_LEN  = 11;
  localparam int AT_TAIL_LEN  = 3;
  localparam int AT_OVERHEAD  = AT_HEAD_LEN + AT_TAIL_LEN + 1;

  typedef struct packed {
    logic [2:0] op;
    logic       two_bytes;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] capacity;
  } spf_op_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [7:0] at_head_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h41;  // A
      4'd1:    c = 8'h54;  // T
      4'd2:    c = 8'h2B;  // +
      4'd3:    c = 8'h4D;  // M
      4'd4:    c = 8'h53;  // S
      4'd5:    c = 8'h47;  // G
      4'd6:    c = 8'h48;  // H
      4'd7:    c = 8'h45;  // E
      4'd8:    c = 8'h58;  // X
      4'd9:    c = 8'h3D;  // =
      4'd10:   c = 8'h22;  // quote
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] at_tail_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h22;  // quote
      2'd1:    c = 8'h0D;  // CR
      2'd2:    c = 8'h0A;  // LF
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/spf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/spf_front.sv */
// Front end: configuration registers, command intake and value conversion.
module spf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            command,
  input  logic [7:0]            channel,
  input  logic signed [23:0]    value_hundredths,
  input  logic [7:0]            out_capacity,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  q_full,
  output logic                  push,
  output spf_pkg::spf_op_t      push_op
);
  import spf_pkg::*;

  logic [7:0] temp_type;
  logic [7:0] analog_type;
  logic [7:0] humid_type;

  logic        a_valid;
  logic [2:0]  a_cmd;
  logic [7:0]  a_channel;
  logic [7:0]  a_capacity;
  logic        a_neg;
  logic [18:0] a_mag;

  logic              accept;
  logic signed [23:0] t_clamped;
  logic signed [23:0] an_clamped;
  logic signed [23:0] h_clamped;
  logic              mag_neg;
  logic [18:0]       mag;

  logic [19:0] recip;
  logic [38:0] prod;
  logic [15:0] quot;
  logic [15:0] val16;

  assign busy   = a_valid && q_full;
  assign accept = start && !busy;
  assign push   = a_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_type   <= TEMP_TYPE_RESET;
      analog_type <= ANALOG_TYPE_RESET;
      humid_type  <= HUMID_TYPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEMP_TYPE:   temp_type   <= cfg_data;
        CFG_ANALOG_TYPE: analog_type <= cfg_data;
        CFG_HUMID_TYPE:  humid_type  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Clamp per record type; split temperatures into sign and magnitude for the divider.
  always_comb begin
    t_clamped  = (value_hundredths < TEMP_MIN) ? TEMP_MIN :
                 ((value_hundredths > TEMP_MAX) ? TEMP_MAX : value_hundredths);
    an_clamped = (value_hundredths < ANALOG_MIN) ? ANALOG_MIN :
                 ((value_hundredths > ANALOG_MAX) ? ANALOG_MAX : value_hundredths);
    h_clamped  = (value_hundredths < HUMID_MIN) ? HUMID_MIN :
                 ((value_hundredths > HUMID_MAX) ? HUMID_MAX : value_hundredths);
    mag_neg = 1'b0;
    case (command)
      CMD_ADD_TEMP: begin
        mag_neg = t_clamped[23];
        mag     = t_clamped[23] ? 19'(-t_clamped) : 19'(t_clamped);
      end
      CMD_ADD_ANALOG: mag = {3'd0, an_clamped[15:0]};
      default:        mag = 19'(h_clamped);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd      <= command;
      a_channel  <= channel;
      a_capacity <= out_capacity;
      a_neg      <= mag_neg;
      a_mag      <= mag;
    end
  end

  // Division by 10 or 50 as a multiply by the reciprocal and a fixed shift.
  always_comb begin
    recip = (a_cmd == CMD_ADD_TEMP) ? TENTH_RECIP : HALFPCT_RECIP;
    prod  = a_mag * recip;
    if (a_cmd == CMD_ADD_TEMP) begin
      quot = prod[TENTH_SHIFT+15:TENTH_SHIFT];
    end else begin
      quot = {8'd0, prod[HALFPCT_SHIFT+7:HALFPCT_SHIFT]};
    end
    if (a_cmd == CMD_ADD_ANALOG) begin
      val16 = a_mag[15:0];
    end else if (a_neg) begin
      val16 = 16'd0 - quot;
    end else begin
      val16 = quot;
    end
  end

  always_comb begin
    push_op           = '0;
    push_op.op        = OP_NOP;
    push_op.b0        = a_channel;
    push_op.capacity  = a_capacity;
    case (a_cmd)
      CMD_CLEAR: push_op.op = OP_CLEAR;
      CMD_ADD_TEMP: begin
        push_op.op        = OP_ADD;
        push_op.two_bytes = 1'b1;
        push_op.b1        = temp_type;
        push_op.b2        = val16[15:8];
        push_op.b3        = val16[7:0];
      end
      CMD_ADD_ANALOG: begin
        push_op.op        = OP_ADD;
        push_op.two_bytes = 1'b1;
        push_op.b1        = analog_type;
        push_op.b2        = val16[15:8];
        push_op.b3        = val16[7:0];
      end
      CMD_ADD_HUMID: begin
        push_op.op = OP_ADD;
        push_op.b1 = humid_type;
        push_op.b2 = val16[7:0];
      end
      CMD_EMIT_AT:  push_op.op = OP_EMIT_AT;
      CMD_EMIT_HEX: push_op.op = OP_EMIT_HEX;
      default:      push_op.op = OP_NOP;
    endcase
  end

endmodule

/* hdl/spf_queue.sv */
// Short operation queue between the front end and the back end.
module spf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spf_pkg::spf_op_t push_op,
  input  logic             pop,
  output spf_pkg::spf_op_t head_op,
  output logic             full,
  output logic             empty
);
  import spf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  spf_op_t       entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full    = (count == NW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

/* hdl/spf_back.sv */
// Back end: payload store, bounds checks and the character streamer.
module spf_back #(
  parameter int PAYLOAD_BYTES = spf_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  output logic             q_pop,
  input  spf_pkg::spf_op_t head_op,
  output logic             strobe,
  output logic [1:0]       status,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             last
);
  import spf_pkg::*;

  localparam int AW = $clog2(PAYLOAD_BYTES);
  localparam int CW = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_HEX  = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] fill;
  logic [7:0]    rec [4];
  logic [1:0]    wr_cnt;
  logic [1:0]    last_wr;
  logic [3:0]    head_idx;
  logic [1:0]    tail_idx;
  logic [CW-1:0] byte_idx;
  logic          nib_lo;
  logic          is_at;

  logic          ram_we;
  logic [7:0]    rd_data;
  logic [CW:0]   fill_after;
  logic          store_full;
  logic [8:0]    need_at;
  logic [8:0]    need_hex;
  logic [8:0]    cap_ext;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign ram_we = (state == S_ADD);

  assign fill_after = (CW+1)'(fill) + (head_op.two_bytes ? (CW+1)'(4) : (CW+1)'(3));
  assign store_full = fill_after > (CW+1)'(PAYLOAD_BYTES);
  assign need_at    = 9'({fill, 1'b0}) + 9'(AT_OVERHEAD);
  assign need_hex   = 9'({fill, 1'b0}) + 9'd1;
  assign cap_ext    = {1'b0, head_op.capacity};

  // The read address idles at byte zero, so the first byte is already in rd_data
  // when the hex stream begins.
  spf_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata (rec[wr_cnt]),
    .raddr (byte_idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      strobe   <= 1'b0;
      byte_idx <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          byte_idx <= '0;
          if (!q_empty) begin
            status     <= STATUS_OK;
            out_char   <= 8'h00;
            char_valid <= 1'b0;
            last       <= 1'b1;
            case (head_op.op)
              OP_CLEAR: begin
                fill   <= '0;
                strobe <= 1'b1;
              end
              OP_ADD: begin
                strobe <= 1'b1;
                if (store_full) begin
                  status <= STATUS_FULL;
                end else begin
                  rec[0]  <= head_op.b0;
                  rec[1]  <= head_op.b1;
                  rec[2]  <= head_op.b2;
                  rec[3]  <= head_op.b3;
                  last_wr <= head_op.two_bytes ? 2'd3 : 2'd2;
                  wr_cnt  <= 2'd0;
                  state   <= S_ADD;
                end
              end
              OP_EMIT_AT: begin
                if (cap_ext < need_at) begin
                  status <= STATUS_SMALL;
                  strobe <= 1'b1;
                end else begin
                  head_idx <= 4'd0;
                  state    <= S_HEAD;
                end
              end
              OP_EMIT_HEX: begin
                if (cap_ext < need_hex) begin
                  status <= STATUS_SMALL;
                  strobe <= 1'b1;
                end else if (fill == '0) begin
                  strobe <= 1'b1;
                end else begin
                  nib_lo <= 1'b0;
                  is_at  <= 1'b0;
                  state  <= S_HEX;
                end
              end
              default: strobe <= 1'b1;
            endcase
          end
        end
        S_ADD: begin
          byte_idx <= '0;
          fill     <= fill + CW'(1);
          wr_cnt   <= wr_cnt + 2'd1;
          if (wr_cnt == last_wr) begin
            state <= S_IDLE;
          end
        end
        S_HEAD: begin
          byte_idx   <= '0;
          strobe     <= 1'b1;
          status     <= STATUS_OK;
          out_char   <= at_head_char(head_idx);
          char_valid <= 1'b1;
          last       <= 1'b0;
          if (head_idx == 4'(AT_HEAD_LEN - 1)) begin
            tail_idx <= 2'd0;
            nib_lo   <= 1'b0;
            is_at    <= 1'b1;
            state    <= (fill == '0) ? S_TAIL : S_HEX;
          end else begin
            head_idx <= head_idx + 4'd1;
          end
        end
        S_HEX: begin
          strobe     <= 1'b1;
          status     <= STATUS_OK;
          char_valid <= 1'b1;
          last       <= 1'b0;
          if (!nib_lo) begin
            out_char <= hex_char(rd_data[7:4]);
            byte_idx <= byte_idx + CW'(1);
            nib_lo   <= 1'b1;
          end else begin
            out_char <= hex_char(rd_data[3:0]);
            nib_lo   <= 1'b0;
            if (byte_idx == fill) begin
              byte_idx <= '0;
              if (is_at) begin
                state <= S_TAIL;
              end else begin
                last  <= 1'b1;
                state <= S_IDLE;
              end
            end
          end
        end
        S_TAIL: begin
          byte_idx   <= '0;
          strobe     <= 1'b1;
          status     <= STATUS_OK;
          out_char   <= at_tail_char(tail_idx);
          char_valid <= 1'b1;
          last       <= (tail_idx == 2'(AT_TAIL_LEN - 1));
          if (tail_idx == 2'(AT_TAIL_LEN - 1)) begin
            state <= S_IDLE;
          end else begin
            tail_idx <= tail_idx + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/sensor_payload_framer_core.sv */
// Top level of the sensor payload framer: front end, operation queue and back end.
//
// Commands are taken whenever busy is low; the front end registers each command,
// converts its value and parks it in a two-entry queue, so up to three commands
// can be in flight while the back end works. The back end handles one command at
// a time: clear, unused codes and rejected commands give one result, registered
// by the idle back end once the command has passed the front register and the
// queue; an add gives its result at once and then writes its three or four record
// bytes into the store, one per cycle through its single write port; a hex emit
// streams 2*N characters and an AT emit 2*N+14, one per cycle, where N is the number
// of stored bytes, paced by the one-byte store read port. Results appear for exactly
// one cycle with strobe high and cannot be held off, so the sink must take one
// character every cycle. Configuration writes take effect at once and should only
// be made while no command is in flight.
`include "sensor_payload_framer_core_assert.svh"

module sensor_payload_framer_core #(
  parameter int PAYLOAD_BYTES = spf_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic [7:0]         channel,
  input  logic signed [23:0] value_hundredths,
  input  logic [7:0]         out_capacity,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               strobe,
  output logic [1:0]         status,
  output logic [7:0]         out_char,
  output logic               char_valid,
  output logic               last
);
  import spf_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  spf_op_t push_op;
  spf_op_t head_op;

  spf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .channel          (channel),
    .value_hundredths (value_hundredths),
    .out_capacity     (out_capacity),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_full           (q_full),
    .push             (q_push),
    .push_op          (push_op)
  );

  spf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  spf_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .head_op    (head_op),
    .strobe     (strobe),
    .status     (status),
    .out_char   (out_char),
    .char_valid (char_valid),
    .last       (last)
  );

  // The front end never offers an operation to a full queue.
  `SPF_ASSERT_IMPLIES(a_push_not_full, clk, rst, q_push, !q_full)
  // A result without a character always closes its command.
  `SPF_ASSERT_IMPLIES(a_nochar_is_last, clk, rst, strobe && !char_valid, last)
  // An error status never comes with a character.
  `SPF_ASSERT_IMPLIES(a_error_no_char, clk, rst, strobe && (status != STATUS_OK), !char_valid)
  // A character stream runs without gaps until its last character.
  `SPF_ASSERT_NEXT(a_stream_no_gap, clk, rst, strobe && !last, strobe)

endmodule

/* sim/tb_sensor_payload_framer_core.sv */
// Self-checking testbench for the sensor payload framer core with a scoreboard class.
module tb_sensor_payload_framer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  localparam int STORE_BYTES = 16;
  localparam int RUN_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX = 10;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [1:0] status;
    logic [7:0] ch;
    logic       valid;
    logic       last;
  } framer_char_t;

  // Mirrors the payload store and predicts every character of every command.
  class framer_scoreboard;
    logic [7:0] store [STORE_BYTES];
    int fill;
    logic [7:0] temp_code, analog_code, humid_code;
    framer_char_t pending_chars [$];
    int errors, items, chars, fulls, smalls, lines;
    string hex_digits = "0123456789ABCDEF";
    string at_head = "AT+MSGHEX=\"";

    function new();
      fill = 0;
      temp_code = TEMP_TYPE_RESET;
      analog_code = ANALOG_TYPE_RESET;
      humid_code = HUMID_TYPE_RESET;
    endfunction

    function void set_type(logic [1:0] idx, logic [7:0] code);
      case (idx)
        CFG_TEMP_TYPE:   temp_code = code;
        CFG_ANALOG_TYPE: analog_code = code;
        CFG_HUMID_TYPE:  humid_code = code;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void queue_char(logic [1:0] st, logic [7:0] c, logic v, logic l);
      framer_char_t e;
      e.status = st;
      e.ch = c;
      e.valid = v;
      e.last = l;
      pending_chars.push_back(e);
    endfunction

    function int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function logic [1:0] append(logic [7:0] chan, logic [7:0] code, logic [15:0] word,
                                bit wide);
      int need;
      need = wide ? 4 : 3;
      if (fill + need > STORE_BYTES) begin
        fulls++;
        return STATUS_FULL;
      end
      store[fill] = chan;
      store[fill + 1] = code;
      if (wide) begin
        store[fill + 2] = word[15:8];
        store[fill + 3] = word[7:0];
      end else begin
        store[fill + 2] = word[7:0];
      end
      fill += need;
      return STATUS_OK;
    endfunction

    function void queue_hex(bit mark_last);
      for (int i = 0; i < fill; i++) begin
        queue_char(STATUS_OK, hex_digits[store[i][7:4]], 1'b1, 1'b0);
        queue_char(STATUS_OK, hex_digits[store[i][3:0]], 1'b1,
                   mark_last && (i == fill - 1));
      end
    endfunction

    function void note_command(logic [2:0] cmd, logic [7:0] chan,
                               logic signed [23:0] val, logic [7:0] cap);
      int v;
      int t;
      logic [1:0] st;
      v = int'(val);
      st = STATUS_OK;
      items++;
      case (cmd)
        CMD_CLEAR: fill = 0;
        CMD_ADD_TEMP: begin
          // Integer division truncates toward zero, as the tenths format requires.
          t = clamp(v, -327680, 327670) / 10;
          st = append(chan, temp_code, t[15:0], 1'b1);
        end
        CMD_ADD_ANALOG: begin
          t = clamp(v, -32768, 32767);
          st = append(chan, analog_code, t[15:0], 1'b1);
        end
        CMD_ADD_HUMID: begin
          t = clamp(v, 0, 10000) / 50;
          st = append(chan, humid_code, {8'd0, t[7:0]}, 1'b0);
        end
        CMD_EMIT_AT: begin
          if (int'(cap) < 2 * fill + 15) begin
            st = STATUS_SMALL;
            smalls++;
          end else begin
            lines++;
            for (int k = 0; k < at_head.len(); k++) begin
              queue_char(STATUS_OK, at_head[k], 1'b1, 1'b0);
            end
            queue_hex(1'b0);
            queue_char(STATUS_OK, 8'h22, 1'b1, 1'b0);
            queue_char(STATUS_OK, 8'h0D, 1'b1, 1'b0);
            queue_char(STATUS_OK, 8'h0A, 1'b1, 1'b1);
            return;
          end
        end
        CMD_EMIT_HEX: begin
          if (int'(cap) < 2 * fill + 1) begin
            st = STATUS_SMALL;
            smalls++;
          end else if (fill > 0) begin
            lines++;
            queue_hex(1'b1);
            return;
          end
        end
        default: ;
      endcase
      queue_char(st, 8'h00, 1'b0, 1'b1);
    endfunction

    function void check_char(logic [1:0] st, logic [7:0] c, logic v, logic l);
      framer_char_t e;
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("%0t: unexpected result status %0d char %02h valid %0b last %0b",
                   $time, st, c, v, l);
        end
        return;
      end
      e = pending_chars.pop_front();
      if (v) chars++;
      if (e.status !== st || e.ch !== c || e.valid !== v || e.last !== l) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("%0t: mismatch, expected status %0d char %02h valid %0b last %0b,",
                   $time, e.status, e.ch, e.valid, e.last);
          $display("  got status %0d char %02h valid %0b last %0b", st, c, v, l);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] command;
  logic [7:0] channel;
  logic signed [23:0] value_hundredths;
  logic [7:0] out_capacity;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic strobe;
  logic [1:0] status;
  logic [7:0] out_char;
  logic char_valid;
  logic last;

  framer_scoreboard sb;
  int cycles;
  int calm_left;

  sensor_payload_framer_core #(
    .PAYLOAD_BYTES(STORE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .channel(channel),
    .value_hundredths(value_hundredths),
    .out_capacity(out_capacity),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .status(status),
    .out_char(out_char),
    .char_valid(char_valid),
    .last(last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Record each command transfer and check each result on the same edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note_command(command, channel, value_hundredths, out_capacity);
    end
    if (!rst && strobe) begin
      sb.check_char(status, out_char, char_valid, last);
    end
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [23:0] pick_value(logic [2:0] cmd);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 2) return 24'($urandom());
    if (r == 2) begin
      case (cmd)
        CMD_ADD_TEMP: begin
          case ($urandom_range(0, 7))
            0: v = -327681;
            1: v = -327680;
            2: v = -327679;
            3: v = -15;
            4: v = 9;
            5: v = 327669;
            6: v = 327670;
            default: v = 327671;
          endcase
        end
        CMD_ADD_ANALOG: begin
          case ($urandom_range(0, 5))
            0: v = -32769;
            1: v = -32768;
            2: v = -1;
            3: v = 0;
            4: v = 32767;
            default: v = 32768;
          endcase
        end
        default: begin
          case ($urandom_range(0, 6))
            0: v = -1;
            1: v = 0;
            2: v = 49;
            3: v = 50;
            4: v = 9999;
            5: v = 10000;
            default: v = 10001;
          endcase
        end
      endcase
      return 24'(v);
    end
    case (cmd)
      CMD_ADD_TEMP:   v = int'($urandom_range(0, 800000)) - 400000;
      CMD_ADD_ANALOG: v = int'($urandom_range(0, 80000)) - 40000;
      default:        v = int'($urandom_range(0, 12000)) - 1000;
    endcase
    return 24'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(logic [2:0] cmd, logic [7:0] chan, logic signed [23:0] val,
                      logic [7:0] cap);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    channel = chan;
    value_hundredths = val;
    out_capacity = cap;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_emit(logic [2:0] cmd);
    int need;
    int r;
    logic [7:0] cap;
    need = (cmd == CMD_EMIT_AT) ? 2 * sb.fill + 15 : 2 * sb.fill + 1;
    r = $urandom_range(0, 99);
    if (r < 70) cap = 8'($urandom_range(need, 255));
    else if (r < 85) cap = 8'(need);
    else if (r < 93) cap = 8'(need - 1);
    else cap = 8'($urandom_range(0, need));
    send(cmd, 8'($urandom()), 24'($urandom()), cap);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // Adds keep writing the store after their result.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_types(logic [7:0] t_code, logic [7:0] a_code, logic [7:0] h_code);
    logic [7:0] codes [3];
    codes[0] = t_code;
    codes[1] = a_code;
    codes[2] = h_code;
    for (int i = 0; i < 3; i++) begin
      cfg_write = 1'b1;
      cfg_index = i[1:0];
      cfg_data = codes[i];
      sb.set_type(i[1:0], codes[i]);
      @(negedge clk);
    end
    cfg_write = 1'b0;
  endtask

  task automatic run_directed();
    send(CMD_CLEAR, 8'h00, 24'sd0, 8'h00);
    send(CMD_ADD_TEMP, 8'h00, 24'sd327670, 8'h00);
    send(CMD_ADD_TEMP, 8'hFF, 24'sh800000, 8'hFF);
    send(CMD_ADD_ANALOG, 8'hA5, 24'sh7FFFFF, 8'h00);
    send(CMD_ADD_HUMID, 8'h5A, -24'sd5, 8'h00);
    // The store holds 15 bytes now, so another record does not fit.
    send(CMD_ADD_HUMID, 8'h01, 24'sd10000, 8'h00);
    send(CMD_EMIT_HEX, 8'h00, 24'sd0, 8'd31);
    send(CMD_EMIT_HEX, 8'h00, 24'sd0, 8'd30);
    send(CMD_EMIT_AT, 8'h00, 24'sd0, 8'd45);
    send(CMD_EMIT_AT, 8'h00, 24'sd0, 8'd44);
    send(CMD_SPARE_LO, 8'hFF, -24'sd1, 8'hFF);
    send(CMD_SPARE_HI, 8'h55, 24'sh555555, 8'hAA);
    send(CMD_CLEAR, 8'hFF, -24'sd1, 8'hFF);
    send(CMD_EMIT_HEX, 8'h00, 24'sd0, 8'd0);
    send(CMD_EMIT_HEX, 8'h00, 24'sd0, 8'd1);
    send(CMD_EMIT_AT, 8'h00, 24'sd0, 8'd15);
    send(CMD_EMIT_AT, 8'h00, 24'sd0, 8'd14);
    send(CMD_ADD_TEMP, 8'h03, -24'sd15, 8'h00);
    send(CMD_ADD_ANALOG, 8'h04, -24'sd32769, 8'h00);
    send(CMD_ADD_HUMID, 8'h05, 24'sd9999, 8'h00);
    send(CMD_ADD_HUMID, 8'h06, 24'sd49, 8'h00);
    send(CMD_ADD_HUMID, 8'h07, 24'sd12345, 8'h00);
    send(CMD_EMIT_AT, 8'h00, 24'sd0, 8'hFF);
    send(CMD_EMIT_HEX, 8'h00, 24'sd0, 8'hFF);
  endtask

  // Mostly whole reports (optional clear, a few records, one emit); the rest is noise.
  task automatic run_random(int count);
    int sent;
    int nadd;
    logic [2:0] cmd;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 2) == 0) begin
          send(CMD_CLEAR, 8'($urandom()), 24'($urandom()), 8'($urandom()));
          sent++;
        end
        nadd = $urandom_range(0, 5);
        repeat (nadd) begin
          cmd = 3'($urandom_range(CMD_ADD_TEMP, CMD_ADD_HUMID));
          send(cmd, 8'($urandom()), pick_value(cmd), 8'($urandom()));
          sent++;
        end
        send_emit(($urandom_range(0, 1) == 0) ? CMD_EMIT_AT : CMD_EMIT_HEX);
        sent++;
      end else begin
        send(3'($urandom_range(0, 7)), 8'($urandom()), 24'($urandom()),
             8'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    calm_left = 0;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_CLEAR;
    channel = 8'h00;
    value_hundredths = 24'sd0;
    out_capacity = 8'h00;
    cfg_write = 1'b0;
    cfg_index = CFG_TEMP_TYPE;
    cfg_data = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    run_directed();
    run_random(100);
    wait_idle();
    write_types(8'h00, 8'h00, 8'h00);
    run_random(100);
    wait_idle();
    write_types(8'hFF, 8'hFF, 8'hFF);
    run_random(100);
    wait_idle();
    write_types(8'($urandom()), 8'($urandom()), 8'($urandom()));
    run_random(100);
    wait_idle();

    $display("Covered %0d commands: %0d emitted lines, %0d characters,",
             sb.items, sb.lines, sb.chars);
    $display("%0d full stores, %0d small destinations; type codes went through reset,",
             sb.fulls, sb.smalls);
    $display("all zeros, all ones and one random set");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
